// ----- hw/rtl/cfrt_pkg.sv -----
`default_nettype none

package cfrt_pkg;

   localparam int CFRT_CHORD_TYPES = 14;
   localparam int CFRT_SHAPES      = 14;
   localparam int CFRT_VOICES      = 4;
   localparam int CFRT_ROOTS       = 12;

   // tone code of an absent voice or an empty shape slot
   localparam logic [3:0] TONE_NONE = 4'd12;
   localparam logic [3:0] TYPE_DIM7 = 4'd9;

   // chord shapes built on C
   localparam logic [3:0] SHAPE_C [CFRT_SHAPES][4] = '{
      '{4'd0, 4'd4, 4'd7,  TONE_NONE},
      '{4'd0, 4'd3, 4'd7,  TONE_NONE},
      '{4'd0, 4'd4, 4'd8,  TONE_NONE},
      '{4'd0, 4'd3, 4'd6,  TONE_NONE},
      '{4'd0, 4'd4, 4'd9,  TONE_NONE},
      '{4'd0, 4'd3, 4'd9,  TONE_NONE},
      '{4'd0, 4'd4, 4'd7,  4'd10},
      '{4'd0, 4'd3, 4'd7,  4'd10},
      '{4'd0, 4'd3, 4'd6,  4'd10},
      '{4'd0, 4'd3, 4'd6,  4'd9},
      '{4'd0, 4'd4, 4'd8,  4'd10},
      '{4'd0, 4'd4, 4'd7,  4'd11},
      '{4'd0, 4'd4, 4'd7,  4'd2},
      '{4'd4, 4'd7, 4'd10, 4'd2}
   };

   typedef logic [CFRT_VOICES-1:0][3:0] tone_vec_type;

   typedef struct packed {
      logic       hit;
      logic [3:0] chord_type;
   } hit_type;

   // slot of a shape transposed to a root; empty slots stay empty
   function automatic logic [3:0] shape_tone(input logic [3:0] shape_idx,
                                             input logic [1:0] slot,
                                             input logic [3:0] root);
      logic [3:0] s;
      logic [4:0] sum;
      s   = SHAPE_C[shape_idx][slot];
      sum = {1'b0, s} + {1'b0, root};
      if (sum >= 5'd12) begin
         sum = sum - 5'd12;
      end
      if (s == TONE_NONE) begin
         return TONE_NONE;
      end
      return sum[3:0];
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/cfrt_root_match.sv -----
`default_nettype none

module cfrt_root_match #(
   parameter int         CHORD_TYPES = cfrt_pkg::CFRT_CHORD_TYPES,
   parameter logic [3:0] ROOT        = 4'd0
) (
   input  cfrt_pkg::tone_vec_type tones,
   output cfrt_pkg::hit_type      result
);

   localparam int NumTypes = (CHORD_TYPES < cfrt_pkg::CFRT_SHAPES) ?
                             CHORD_TYPES : cfrt_pkg::CFRT_SHAPES;

   logic [NumTypes-1:0] type_hit;

   // every equal voice/slot pair counts; a match needs exactly four
   always_comb begin
      logic [4:0] pairs;
      for (int j = 0; j < NumTypes; j++) begin
         pairs = '0;
         for (int m = 0; m < cfrt_pkg::CFRT_VOICES; m++) begin
            for (int k = 0; k < 4; k++) begin
               if (tones[m] == cfrt_pkg::shape_tone(4'(j), 2'(k), ROOT)) begin
                  pairs = pairs + 5'd1;
               end
            end
         end
         type_hit[j] = (pairs == 5'd4);
      end
   end

   // lowest matching type wins
   always_comb begin
      result.hit        = |type_hit;
      result.chord_type = '0;
      for (int j = NumTypes - 1; j >= 0; j--) begin
         if (type_hit[j]) begin
            result.chord_type = 4'(j);
         end
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/chord_root_and_type_finder.sv -----
`default_nettype none

// channel | dir | handshake           | payload
// req     | in  | req_valid/req_ready | req_voice0..3_pitch, req_voice0..3_present
// rsp     | out | rsp_valid/rsp_ready | rsp_chord_found, rsp_root_tone, rsp_chord_type
//
// One item per cycle sustained while rsp_ready is high; rsp turns valid once
// the item passes the input register, then tone reduction, 12x14 shape match
// and root pick into the result register.
// The last-root register is read and written in the pick stage only.
// Synchronous reset clears the valid flags and last root (C).
// A stalled rsp holds; the input register still takes an item if empty.

module chord_root_and_type_finder #(
   parameter int CHORD_TYPES = cfrt_pkg::CFRT_CHORD_TYPES
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [6:0] req_voice0_pitch,
   input  wire logic [6:0] req_voice1_pitch,
   input  wire logic [6:0] req_voice2_pitch,
   input  wire logic [6:0] req_voice3_pitch,
   input  wire logic       req_voice0_present,
   input  wire logic       req_voice1_present,
   input  wire logic       req_voice2_present,
   input  wire logic       req_voice3_present,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic            rsp_chord_found,
   output logic [3:0]      rsp_root_tone,
   output logic [3:0]      rsp_chord_type
);

   localparam int Voices = cfrt_pkg::CFRT_VOICES;
   localparam int Roots  = cfrt_pkg::CFRT_ROOTS;

   // pitch mod 12 for 0..127: reciprocal multiply, exact over this range
   function automatic logic [3:0] pitch_tone(input logic [6:0] pitch);
      logic [12:0] prod;
      logic [3:0]  quot;
      logic [6:0]  rem;
      prod = 13'(pitch) * 13'd43;
      quot = prod[12:9];
      rem  = pitch - 7'(quot) * 7'd12;
      return rem[3:0];
   endfunction

   logic                 s1_valid_ff, s1_valid_in;
   logic [3:0][6:0]      s1_pitch_ff;
   logic [3:0]           s1_present_ff;
   logic                 s1_advance;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_found_ff;
   logic [3:0]           rsp_root_ff;
   logic [3:0]           rsp_type_ff;

   logic [3:0]           last_root_ff, last_root_in;

   cfrt_pkg::tone_vec_type tones;
   cfrt_pkg::hit_type      hits [Roots];

   logic                 found;
   logic [3:0]           pick_root;
   logic [3:0]           pick_type;

   assign s1_advance = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = !s1_valid_ff || s1_advance;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_valid && req_ready) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      if (req_valid && req_ready) begin
         s1_pitch_ff   <= {req_voice3_pitch, req_voice2_pitch,
                           req_voice1_pitch, req_voice0_pitch};
         s1_present_ff <= {req_voice3_present, req_voice2_present,
                           req_voice1_present, req_voice0_present};
      end
   end

   always_comb begin
      for (int i = 0; i < Voices; i++) begin
         tones[i] = s1_present_ff[i] ? pitch_tone(s1_pitch_ff[i]) : cfrt_pkg::TONE_NONE;
      end
   end

   for (genvar r = 0; r < Roots; r++) begin : g_root
      cfrt_root_match #(
         .CHORD_TYPES (CHORD_TYPES),
         .ROOT        (4'(r))
      ) u_match (
         .tones  (tones),
         .result (hits[r])
      );
   end

   // root pick: voice tones in voice order, then C upward; dim7 prefers last root
   always_comb begin
      logic [2:0] present_cnt;
      logic [2:0] same_cnt;
      logic       enough;
      logic       voice_hit;
      logic [3:0] voice_root;
      logic [3:0] voice_type;
      logic       any_hit;
      logic [3:0] low_root;
      logic [3:0] low_type;
      logic       last_sounds;

      present_cnt = '0;
      same_cnt    = '0;
      for (int i = 0; i < Voices; i++) begin
         present_cnt = present_cnt + 3'(s1_present_ff[i]);
         for (int j = i + 1; j < Voices; j++) begin
            if (tones[i] != cfrt_pkg::TONE_NONE && tones[j] == tones[i]) begin
               same_cnt = same_cnt + 3'd1;
            end
         end
      end
      enough = ({1'b0, present_cnt} >= ({1'b0, same_cnt} + 4'd3));

      voice_hit  = 1'b0;
      voice_root = '0;
      voice_type = '0;
      for (int i = Voices - 1; i >= 0; i--) begin
         for (int r = 0; r < Roots; r++) begin
            if (tones[i] == 4'(r) && hits[r].hit) begin
               voice_hit  = 1'b1;
               voice_root = 4'(r);
               voice_type = hits[r].chord_type;
            end
         end
      end

      any_hit  = 1'b0;
      low_root = '0;
      low_type = '0;
      for (int r = Roots - 1; r >= 0; r--) begin
         if (hits[r].hit) begin
            any_hit  = 1'b1;
            low_root = 4'(r);
            low_type = hits[r].chord_type;
         end
      end

      last_sounds = 1'b0;
      for (int i = 0; i < Voices; i++) begin
         if (tones[i] == last_root_ff) begin
            last_sounds = 1'b1;
         end
      end

      found     = enough && any_hit;
      pick_root = voice_hit ? voice_root : low_root;
      pick_type = voice_hit ? voice_type : low_type;
      if (pick_type == cfrt_pkg::TYPE_DIM7 && last_sounds) begin
         pick_root = last_root_ff;
      end
      if (!found) begin
         pick_root = '0;
         pick_type = '0;
      end
   end

   always_comb begin
      last_root_in = last_root_ff;
      if (s1_advance && found) begin
         last_root_in = pick_root;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s1_advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         last_root_ff <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         last_root_ff <= last_root_in;
      end
      if (s1_advance) begin
         rsp_found_ff <= found;
         rsp_root_ff  <= pick_root;
         rsp_type_ff  <= pick_type;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_chord_found = rsp_found_ff;
   assign rsp_root_tone   = rsp_root_ff;
   assign rsp_chord_type  = rsp_type_ff;

   a_last_root_only_on_found: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && !$stable(last_root_ff)) |-> $past(s1_advance && found))
      else $error("last root changed without a found chord");

   a_root_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_root_ff <= 4'd11))
      else $error("root tone out of range");

   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_advance) |=> s1_valid_ff)
      else $error("input stage item lost while stalled");

   a_found_updates_root: assert property (@(posedge clock) disable iff (reset)
      (s1_advance && found) |=> (last_root_ff == rsp_root_ff))
      else $error("last root differs from delivered root");

endmodule

`default_nettype wire

// ----- test/chord_root_and_type_finder_tb.sv -----
`timescale 1ns / 1ps

module chord_root_and_type_finder_tb;

   typedef enum logic [3:0] {
      MAJOR, MINOR, AUGMENTED, DIMINISHED, SIXTH_NO5, MINOR_SIXTH_NO5,
      SEVENTH, MINOR_SEVENTH, HALF_DIM_SEVENTH, FULL_DIM_SEVENTH,
      AUG_SEVENTH, MAJOR_SEVENTH, NINTH, SEVENTH_NINTH_NO_ROOT
   } chord_kind_type;

   typedef struct packed {
      logic       found;
      logic [3:0] root;
      logic [3:0] kind;
   } chord_call_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [6:0] req_voice0_pitch = '0;
   logic [6:0] req_voice1_pitch = '0;
   logic [6:0] req_voice2_pitch = '0;
   logic [6:0] req_voice3_pitch = '0;
   logic       req_voice0_present = 1'b0;
   logic       req_voice1_present = 1'b0;
   logic       req_voice2_present = 1'b0;
   logic       req_voice3_present = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic       rsp_chord_found;
   logic [3:0] rsp_root_tone;
   logic [3:0] rsp_chord_type;

   chord_call_type chord_calls_q[$];
   logic [3:0]     held_root = 4'd0;
   int             mismatch_count = 0;
   int             send_idle_pct = 0;
   int             recv_stall_pct = 0;

   chord_root_and_type_finder uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_voice0_pitch   (req_voice0_pitch),
      .req_voice1_pitch   (req_voice1_pitch),
      .req_voice2_pitch   (req_voice2_pitch),
      .req_voice3_pitch   (req_voice3_pitch),
      .req_voice0_present (req_voice0_present),
      .req_voice1_present (req_voice1_present),
      .req_voice2_present (req_voice2_present),
      .req_voice3_present (req_voice3_present),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_chord_found    (rsp_chord_found),
      .rsp_root_tone      (rsp_root_tone),
      .rsp_chord_type     (rsp_chord_type)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // slot k of the shape built on C sits in bits [k]
   function automatic logic [3:0][3:0] chord_shape(input chord_kind_type kind);
      case (kind)
         MAJOR:                 return {cfrt_pkg::TONE_NONE, 4'd7, 4'd4, 4'd0};
         MINOR:                 return {cfrt_pkg::TONE_NONE, 4'd7, 4'd3, 4'd0};
         AUGMENTED:             return {cfrt_pkg::TONE_NONE, 4'd8, 4'd4, 4'd0};
         DIMINISHED:            return {cfrt_pkg::TONE_NONE, 4'd6, 4'd3, 4'd0};
         SIXTH_NO5:             return {cfrt_pkg::TONE_NONE, 4'd9, 4'd4, 4'd0};
         MINOR_SIXTH_NO5:       return {cfrt_pkg::TONE_NONE, 4'd9, 4'd3, 4'd0};
         SEVENTH:               return {4'd10, 4'd7, 4'd4, 4'd0};
         MINOR_SEVENTH:         return {4'd10, 4'd7, 4'd3, 4'd0};
         HALF_DIM_SEVENTH:      return {4'd10, 4'd6, 4'd3, 4'd0};
         FULL_DIM_SEVENTH:      return {4'd9, 4'd6, 4'd3, 4'd0};
         AUG_SEVENTH:           return {4'd10, 4'd8, 4'd4, 4'd0};
         MAJOR_SEVENTH:         return {4'd11, 4'd7, 4'd4, 4'd0};
         NINTH:                 return {4'd2, 4'd7, 4'd4, 4'd0};
         SEVENTH_NINTH_NO_ROOT: return {4'd2, 4'd10, 4'd7, 4'd4};
         default:               return {4{cfrt_pkg::TONE_NONE}};
      endcase
   endfunction

   function automatic logic [3:0] transpose(input logic [3:0] s, input logic [3:0] root);
      if (s == cfrt_pkg::TONE_NONE) return cfrt_pkg::TONE_NONE;
      return 4'((int'(s) + int'(root)) % 12);
   endfunction

   // first type on this root whose shape pairs up with the voices exactly four times
   function automatic chord_call_type match_on_root(input logic [3:0][3:0] tone,
                                                    input logic [3:0] root);
      chord_call_type  call;
      logic [3:0][3:0] shape;
      int              pairs;
      int              n_types;
      call    = '0;
      n_types = (cfrt_pkg::CFRT_CHORD_TYPES < cfrt_pkg::CFRT_SHAPES) ?
                cfrt_pkg::CFRT_CHORD_TYPES : cfrt_pkg::CFRT_SHAPES;
      for (int t = 0; t < n_types; t++) begin
         shape = chord_shape(chord_kind_type'(t));
         pairs = 0;
         for (int m = 0; m < 4; m++)
            for (int k = 0; k < 4; k++)
               if (tone[m] == transpose(shape[k], root)) pairs++;
         if (pairs == 4) begin
            call.found = 1'b1;
            call.root  = root;
            call.kind  = 4'(t);
            // diminished seventh is symmetric: keep the previous root if it sounds
            if (t == FULL_DIM_SEVENTH)
               for (int v = 0; v < 4; v++)
                  if (tone[v] == held_root) call.root = held_root;
            return call;
         end
      end
      return call;
   endfunction

   function automatic chord_call_type predict_chord_call(input logic [3:0][6:0] pitch,
                                                         input logic [3:0] present);
      chord_call_type  call;
      logic [3:0][3:0] tone;
      logic [3:0]      cand;
      int              n_present;
      int              n_same;
      call      = '0;
      n_present = 0;
      n_same    = 0;
      for (int v = 0; v < 4; v++) begin
         if (present[v]) begin
            tone[v] = 4'(pitch[v] % 12);
            n_present++;
         end else begin
            tone[v] = cfrt_pkg::TONE_NONE;
         end
      end
      for (int i = 0; i < 4; i++)
         if (tone[i] != cfrt_pkg::TONE_NONE)
            for (int j = i + 1; j < 4; j++)
               if (tone[j] == tone[i]) n_same++;
      if (n_present - n_same >= 3) begin
         // voice tones in voice order first, then C up to B
         for (int i = 0; i < 16 && !call.found; i++) begin
            cand = (i < 4) ? tone[i] : 4'(i - 4);
            if (cand != cfrt_pkg::TONE_NONE) call = match_on_root(tone, cand);
         end
      end
      if (call.found) held_root = call.root;
      return call;
   endfunction

   task automatic send_chord(input logic [3:0][6:0] pitch, input logic [3:0] present);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid          <= 1'b1;
      req_voice0_pitch   <= pitch[0];
      req_voice1_pitch   <= pitch[1];
      req_voice2_pitch   <= pitch[2];
      req_voice3_pitch   <= pitch[3];
      req_voice0_present <= present[0];
      req_voice1_present <= present[1];
      req_voice2_present <= present[2];
      req_voice3_present <= present[3];
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      chord_calls_q.push_back(predict_chord_call(pitch, present));
   endtask

   // voices in random order and octave; an empty slot is left silent or doubles a tone
   task automatic send_shape(input chord_kind_type kind, input logic [3:0] root);
      logic [3:0][3:0] shape;
      logic [3:0][3:0] tone;
      logic [3:0][6:0] pitch;
      logic [3:0]      present;
      logic [3:0]      swap;
      int              j;
      int              octave;
      shape = chord_shape(kind);
      for (int k = 0; k < 4; k++) tone[k] = transpose(shape[k], root);
      if (tone[3] == cfrt_pkg::TONE_NONE && $urandom_range(1)) tone[3] = tone[$urandom_range(2)];
      for (int k = 3; k > 0; k--) begin
         j       = $urandom_range(k);
         swap    = tone[k];
         tone[k] = tone[j];
         tone[j] = swap;
      end
      for (int k = 0; k < 4; k++) begin
         if (tone[k] == cfrt_pkg::TONE_NONE) begin
            present[k] = 1'b0;
            pitch[k]   = 7'($urandom_range(127));
         end else begin
            present[k] = 1'b1;
            octave     = $urandom_range((127 - int'(tone[k])) / 12);
            pitch[k]   = 7'(int'(tone[k]) + 12 * octave);
         end
      end
      send_chord(pitch, present);
   endtask

   task automatic wait_for_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (chord_calls_q.size() != 0) @(posedge clock);
   endtask

   task automatic test_field_extremes();
      send_chord({7'd0, 7'd0, 7'd0, 7'd0}, 4'b0000);
      send_chord({7'd127, 7'd127, 7'd127, 7'd127}, 4'b0000);
      send_chord({7'd127, 7'd127, 7'd127, 7'd127}, 4'b1111);
      send_chord({7'd127, 7'd7, 7'd4, 7'd0}, 4'b1111);
      send_chord({7'd0, 7'd2, 7'd11, 7'd127}, 4'b1111);
   endtask

   task automatic test_special_cases();
      // two tones only, then three of one tone
      send_chord({7'd64, 7'd52, 7'd48, 7'd60}, 4'b1111);
      send_chord({7'd64, 7'd36, 7'd48, 7'd60}, 4'b1111);
      // three tones that fit no shape
      send_chord({7'd0, 7'd62, 7'd61, 7'd60}, 4'b0111);
      // silent voice with a clashing pitch is ignored
      send_chord({7'd1, 7'd67, 7'd64, 7'd60}, 4'b0111);
      // doubled root stands in for the missing fifth of a seventh
      send_chord({7'd60, 7'd58, 7'd52, 7'd48}, 4'b1111);
      // G major sets the last root; dim seventh with G sounding, then without it
      send_chord({7'd74, 7'd62, 7'd59, 7'd55}, 4'b0111);
      send_chord({7'd55, 7'd52, 7'd49, 7'd46}, 4'b1111);
      send_chord({7'd57, 7'd54, 7'd51, 7'd48}, 4'b1111);
   endtask

   task automatic test_chord_types();
      for (int t = 0; t < cfrt_pkg::CFRT_SHAPES; t++)
         send_shape(chord_kind_type'(t), 4'($urandom_range(11)));
   endtask

   task automatic test_random_traffic(input int n_items, input int idle_pct,
                                      input int stall_pct);
      logic [3:0][6:0] pitch;
      chord_kind_type  kind;
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      for (int n = 0; n < n_items; n++) begin
         if ($urandom_range(99) < 70) begin
            kind = ($urandom_range(9) == 0) ? FULL_DIM_SEVENTH
                                            : chord_kind_type'($urandom_range(13));
            send_shape(kind, 4'($urandom_range(11)));
         end else begin
            for (int v = 0; v < 4; v++) pitch[v] = 7'($urandom_range(127));
            send_chord(pitch, 4'($urandom_range(15)));
         end
      end
   endtask

   task automatic test_pause_until_drained();
      send_idle_pct  = 0;
      recv_stall_pct = 46;
      for (int n = 0; n < 6; n++)
         send_shape(chord_kind_type'($urandom_range(13)), 4'($urandom_range(11)));
      wait_for_results();
      for (int n = 0; n < 6; n++)
         send_shape(chord_kind_type'($urandom_range(13)), 4'($urandom_range(11)));
   endtask

   always @(negedge clock) begin
      rsp_ready <= !reset && ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      chord_call_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (chord_calls_q.size() == 0) begin
            $error("unexpected result transfer: found %0d root %0d type %0d",
                   rsp_chord_found, rsp_root_tone, rsp_chord_type);
            mismatch_count++;
         end else begin
            want = chord_calls_q.pop_front();
            if (rsp_chord_found !== want.found) begin
               $error("rsp_chord_found: expected %0d, got %0d", want.found, rsp_chord_found);
               mismatch_count++;
            end
            if (rsp_root_tone !== want.root) begin
               $error("rsp_root_tone: expected %0d, got %0d", want.root, rsp_root_tone);
               mismatch_count++;
            end
            if (rsp_chord_type !== want.kind) begin
               $error("rsp_chord_type: expected %0d, got %0d", want.kind, rsp_chord_type);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      #2ms;
      $display("chord_root_and_type_finder_tb: done, errors");
      $finish;
   end

   initial begin
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      test_field_extremes();
      test_special_cases();
      test_chord_types();
      test_random_traffic(125, 0, 0);
      test_random_traffic(125, 46, 0);
      test_pause_until_drained();
      test_random_traffic(125, 0, 46);
      test_random_traffic(125, 31, 31);
      wait_for_results();
      // two-stage pipe: the extra wait catches any stray transfer
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("chord_root_and_type_finder_tb: done, clean");
      end else begin
         $display("chord_root_and_type_finder_tb: done, errors");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
hw/rtl/cfrt_pkg.sv
hw/rtl/cfrt_root_match.sv
hw/rtl/chord_root_and_type_finder.sv
test/chord_root_and_type_finder_tb.sv
